/* rtl/sqf_pkg.sv */
`default_nettype none

package sqf_pkg;

   localparam int SAMPLE_W = 32;
   localparam int COEF_W   = 32;
   localparam int STATE_W  = 64;
   localparam int CSR_IDX_W = 4;

   // multiplier operands: 34-bit signed data half, 33-bit signed coefficient
   localparam int MX_W = 34;
   localparam int MC_W = 33;

   localparam int FRAC_BITS = 30;
   localparam int IO_SHIFT  = 24;

   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] LAST_STEP = 5'd19;

   localparam logic [CSR_IDX_W-1:0] CSR_A1       = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_A2       = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_B0 = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA_B0  = 4'd3;

   typedef enum logic [2:0] {
      XS_AD1,
      XS_AD2,
      XS_BD1,
      XS_BD2,
      XS_INA,
      XS_INB
   } x_sel_type;

   typedef enum logic [2:0] {
      CS_A1,
      CS_A2,
      CS_AB0,
      CS_NAB0,
      CS_BB0,
      CS_B2B0
   } c_sel_type;

   typedef enum logic [1:0] {
      BASE_KEEP,
      BASE_ZERO,
      BASE_U40
   } base_type;

   typedef struct packed {
      logic      load;     // item accepted: accumulator takes the scaled sample
      logic      mul_en;
      x_sel_type x_sel;
      c_sel_type c_sel;
      logic      hi_half;  // upper operand half, else lower 30 bits
      logic      neg;      // subtract this partial product
      base_type  acc_base;
      logic      save_a;
      logic      save_va;
      logic      save_b;
      logic      finish;
   } dp_cmd_type;

endpackage

`default_nettype wire

/* rtl/sqf_ctrl.sv */
`default_nettype none

module sqf_ctrl (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output sqf_pkg::dp_cmd_type cmd
);
   import sqf_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept, slot_free, finish;
   dp_cmd_type        step_cmd;

   // Product schedule. A product issued at step n is accumulated at step n+1.
   function automatic dp_cmd_type step_cmd_f(input logic [STEP_W-1:0] s);
      dp_cmd_type c;
      c          = '0;
      c.x_sel    = XS_AD1;
      c.c_sel    = CS_A1;
      c.acc_base = BASE_KEEP;
      case (s)
         5'd0:  begin c.mul_en = 1'b1; c.x_sel = XS_AD1; c.c_sel = CS_A1; c.neg = 1'b1; end
         5'd1:  begin
            c.mul_en = 1'b1; c.x_sel = XS_AD1; c.c_sel = CS_A1; c.neg = 1'b1; c.hi_half = 1'b1;
         end
         5'd2:  begin c.mul_en = 1'b1; c.x_sel = XS_AD2; c.c_sel = CS_A2; c.neg = 1'b1; end
         5'd3:  begin
            c.mul_en = 1'b1; c.x_sel = XS_AD2; c.c_sel = CS_A2; c.neg = 1'b1; c.hi_half = 1'b1;
         end
         5'd4:  begin c.mul_en = 1'b1; c.x_sel = XS_AD2; c.c_sel = CS_NAB0; end
         5'd5:  begin
            // accumulator holds the new alpha state here
            c.mul_en = 1'b1; c.x_sel = XS_AD2; c.c_sel = CS_NAB0; c.hi_half = 1'b1;
            c.save_a = 1'b1; c.acc_base = BASE_ZERO;
         end
         5'd6:  begin c.mul_en = 1'b1; c.x_sel = XS_INA; c.c_sel = CS_AB0; end
         5'd7:  begin c.mul_en = 1'b1; c.x_sel = XS_INA; c.c_sel = CS_AB0; c.hi_half = 1'b1; end
         5'd8:  begin c.mul_en = 1'b1; c.x_sel = XS_BD1; c.c_sel = CS_A1; c.neg = 1'b1; end
         5'd9:  begin
            c.mul_en = 1'b1; c.x_sel = XS_BD1; c.c_sel = CS_A1; c.neg = 1'b1; c.hi_half = 1'b1;
            c.save_va = 1'b1; c.acc_base = BASE_U40;
         end
         5'd10: begin c.mul_en = 1'b1; c.x_sel = XS_BD2; c.c_sel = CS_A2; c.neg = 1'b1; end
         5'd11: begin
            c.mul_en = 1'b1; c.x_sel = XS_BD2; c.c_sel = CS_A2; c.neg = 1'b1; c.hi_half = 1'b1;
         end
         5'd12: begin c.mul_en = 1'b1; c.x_sel = XS_BD1; c.c_sel = CS_B2B0; end
         5'd13: begin
            c.mul_en = 1'b1; c.x_sel = XS_BD1; c.c_sel = CS_B2B0; c.hi_half = 1'b1;
            c.save_b = 1'b1; c.acc_base = BASE_ZERO;
         end
         5'd14: begin c.mul_en = 1'b1; c.x_sel = XS_BD2; c.c_sel = CS_BB0; end
         5'd15: begin c.mul_en = 1'b1; c.x_sel = XS_BD2; c.c_sel = CS_BB0; c.hi_half = 1'b1; end
         5'd16: begin c.mul_en = 1'b1; c.x_sel = XS_INB; c.c_sel = CS_BB0; end
         5'd17: begin c.mul_en = 1'b1; c.x_sel = XS_INB; c.c_sel = CS_BB0; c.hi_half = 1'b1; end
         default: c.mul_en = 1'b0;
      endcase
      return c;
   endfunction

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign accept    = (state_ff == ST_IDLE) && req_valid;
   assign finish    = (state_ff == ST_RUN) && (step_ff == LAST_STEP) && slot_free;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign step_cmd  = step_cmd_f(step_ff);

   always_comb begin
      cmd          = '0;
      cmd.x_sel    = step_cmd.x_sel;
      cmd.c_sel    = step_cmd.c_sel;
      cmd.hi_half  = step_cmd.hi_half;
      cmd.neg      = step_cmd.neg;
      cmd.acc_base = BASE_KEEP;
      cmd.load     = accept;
      cmd.finish   = finish;
      if (state_ff == ST_RUN) begin
         cmd.mul_en   = step_cmd.mul_en;
         cmd.acc_base = step_cmd.acc_base;
         cmd.save_a   = step_cmd.save_a;
         cmd.save_va  = step_cmd.save_va;
         cmd.save_b   = step_cmd.save_b;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (accept) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (step_ff != LAST_STEP) begin
               step_in = step_ff + 5'd1;
            end else if (slot_free) begin
               state_in     = ST_IDLE;
               step_in      = '0;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
            step_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/sqf_datapath.sv */
`default_nettype none

module sqf_datapath (
   input  wire                  clock,
   input  wire                  reset,
   input  wire  sqf_pkg::dp_cmd_type cmd,
   input  wire  signed [31:0]   req_sample,
   input  wire                  csr_wr_en,
   input  wire  [3:0]           csr_index,
   input  wire  [31:0]          csr_wdata,
   output logic signed [31:0]   rsp_alpha_out,
   output logic signed [31:0]   rsp_beta_out
);
   import sqf_pkg::*;

   logic signed [COEF_W-1:0]  a1_ff, a2_ff, ab0_ff, bb0_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic [STATE_W-1:0] ad1_ff, ad2_ff, bd1_ff, bd2_ff;
   logic [STATE_W-1:0] ina_ff, inb_ff, va_ff;
   logic [STATE_W-1:0] acc_ff, acc_in;
   logic [STATE_W-1:0] prod_ff;
   logic               prod_vld_ff, prod_hi_ff, prod_neg_ff;
   logic signed [31:0] alpha_ff, beta_ff;

   logic [STATE_W-1:0]     x_op, base, term, u40_now, u40_held;
   logic signed [MX_W-1:0] mx;
   logic signed [MC_W-1:0] mc;
   logic signed [MX_W+MC_W-1:0] mp;

   function automatic logic [STATE_W-1:0] scale_in(input logic [SAMPLE_W-1:0] s);
      return {{(STATE_W-SAMPLE_W-IO_SHIFT){s[SAMPLE_W-1]}}, s, {IO_SHIFT{1'b0}}};
   endfunction

   // Q40 -> Q16 with saturation to 32 bits
   function automatic logic [31:0] to_out(input logic [STATE_W-1:0] v);
      logic [STATE_W-IO_SHIFT-1:0] s;
      s = v[STATE_W-1:IO_SHIFT];
      if (s[STATE_W-IO_SHIFT-1:31] == '0 || s[STATE_W-IO_SHIFT-1:31] == '1)
         return s[31:0];
      else if (s[STATE_W-IO_SHIFT-1])
         return 32'h8000_0000;
      else
         return 32'h7FFF_FFFF;
   endfunction

   assign u40_now  = scale_in(req_sample);
   assign u40_held = scale_in(sample_ff);

   always_comb begin
      case (cmd.x_sel)
         XS_AD1:  x_op = ad1_ff;
         XS_AD2:  x_op = ad2_ff;
         XS_BD1:  x_op = bd1_ff;
         XS_BD2:  x_op = bd2_ff;
         XS_INA:  x_op = ina_ff;
         XS_INB:  x_op = inb_ff;
         default: x_op = '0;
      endcase
   end

   // derived coefficients are exact at 33 bits
   always_comb begin
      case (cmd.c_sel)
         CS_A1:   mc = MC_W'(a1_ff);
         CS_A2:   mc = MC_W'(a2_ff);
         CS_AB0:  mc = MC_W'(ab0_ff);
         CS_NAB0: mc = -MC_W'(ab0_ff);
         CS_BB0:  mc = MC_W'(bb0_ff);
         CS_B2B0: mc = MC_W'(bb0_ff) <<< 1;
         default: mc = '0;
      endcase
   end

   // x*c >>> 30 = (x asr 30)*c + ((x & mask)*c >>> 30), done as two passes
   assign mx = cmd.hi_half ? x_op[STATE_W-1:FRAC_BITS]
                           : {{(MX_W-FRAC_BITS){1'b0}}, x_op[FRAC_BITS-1:0]};
   assign mp = mx * mc;

   assign term = prod_hi_ff ? prod_ff
                            : {{FRAC_BITS{prod_ff[STATE_W-1]}}, prod_ff[STATE_W-1:FRAC_BITS]};

   always_comb begin
      case (cmd.acc_base)
         BASE_KEEP: base = acc_ff;
         BASE_ZERO: base = '0;
         BASE_U40:  base = u40_held;
         default:   base = acc_ff;
      endcase
   end

   always_comb begin
      if (cmd.load)
         acc_in = u40_now;
      else if (prod_vld_ff)
         acc_in = prod_neg_ff ? base - term : base + term;
      else
         acc_in = base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a1_ff       <= '0;
         a2_ff       <= '0;
         ab0_ff      <= '0;
         bb0_ff      <= '0;
         ad1_ff      <= '0;
         ad2_ff      <= '0;
         bd1_ff      <= '0;
         bd2_ff      <= '0;
         prod_vld_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_A1:       a1_ff  <= csr_wdata;
               CSR_A2:       a2_ff  <= csr_wdata;
               CSR_ALPHA_B0: ab0_ff <= csr_wdata;
               CSR_BETA_B0:  bb0_ff <= csr_wdata;
               default: ;
            endcase
         end
         prod_vld_ff <= cmd.mul_en;
         if (cmd.finish) begin
            ad2_ff <= ad1_ff;
            ad1_ff <= ina_ff;
            bd2_ff <= bd1_ff;
            bd1_ff <= inb_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      prod_ff     <= mp[STATE_W-1:0];
      prod_hi_ff  <= cmd.hi_half;
      prod_neg_ff <= cmd.neg;
      if (cmd.load)    sample_ff <= req_sample;
      if (cmd.save_a)  ina_ff    <= acc_ff;
      if (cmd.save_va) va_ff     <= acc_ff;
      if (cmd.save_b)  inb_ff    <= acc_ff;
      if (cmd.finish) begin
         alpha_ff <= to_out(va_ff);
         beta_ff  <= to_out(acc_ff);
      end
   end

   assign rsp_alpha_out = alpha_ff;
   assign rsp_beta_out  = beta_ff;

endmodule

`default_nettype wire

/* rtl/sogi_quadrature_filter_top.sv */
// SOGI quadrature filter: one Q16.16 sample in, in-phase and quadrature
// Q16.16 results out, through two biquads that share a1/a2.
// Input channel req_*: an item is taken when req_valid is high and req_stall
// low. req_stall is high while an item is being worked on.
// Result channel rsp_*: rsp_valid with rsp_alpha_out / rsp_beta_out, held
// while rsp_stall is high.
// Coefficients (Q30) are written on csr_wr_en with csr_index 0..3:
// a1, a2, alpha b0, beta b0. Other indexes are ignored. Write only when idle.
// A new item is taken only after the previous result has been registered, so
// items are never overlapped in the block.
// The schedule comes from the single 34x33 multiplier: nine coefficient
// products, each done in two passes (lower 30 bits, then upper 34 bits).
// If the previous result is still stalled when a new one is ready, the
// block holds its last step until the output register frees up.
// Reset (synchronous, active high) clears coefficients, filter state and
// the output valid.
`default_nettype none

module sogi_quadrature_filter_top (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire  signed [31:0] req_sample,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic signed [31:0] rsp_alpha_out,
   output logic signed [31:0] rsp_beta_out,
   input  wire                csr_wr_en,
   input  wire  [3:0]         csr_index,
   input  wire  [31:0]        csr_wdata
);
   import sqf_pkg::*;

   dp_cmd_type cmd;

   sqf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   sqf_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_sample    (req_sample),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_alpha_out (rsp_alpha_out),
      .rsp_beta_out  (rsp_beta_out)
   );

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;
   import sqf_pkg::*;

   localparam int COEF_FRAC = 30;
   localparam int OUT_SHIFT = 24;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE_CYCLES = 2;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS = 108;
   localparam int HOLD_AT = 600;
   localparam int HOLD_CYCLES = 300;
   localparam int GRID_PEAK = 400 * 65536;
   localparam int PLAN_ROWS = 31;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_FIRST = CSR_BETA_B0 + CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LAST = '1;

   // 50 Hz grid, 10 kHz sampling, gain sqrt(2)
   localparam logic signed [31:0] LINE_A1 = -32'sd2099795552;
   localparam logic signed [31:0] LINE_A2 = 32'sd1027085594;
   localparam logic signed [31:0] LINE_ALPHA_B0 = 32'sd23329188;
   localparam logic signed [31:0] LINE_BETA_B0 = 32'sd366468;

   typedef logic signed [63:0] q40_type;
   localparam q40_type OUT_MAX = 64'sd2147483647;
   localparam q40_type OUT_MIN = -64'sd2147483648;

   typedef struct packed {
      logic signed [31:0] alpha;
      logic signed [31:0] beta;
   } filter_out_type;

   typedef enum logic [1:0] {ROW_WRITE, ROW_SAMPLE, ROW_SAMPLE_KNOWN} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [31:0]           data;
      logic [31:0]           alpha;
      logic [31:0]           beta;
   } plan_row_type;

   typedef enum logic [1:0] {COEF_LINE, COEF_RANDOM, COEF_EXTREME} coef_style_type;
   typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_pattern_type;
   typedef enum logic [1:0] {SPAN_FULL, SPAN_TINY, SPAN_GRID} sample_span_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [31:0] req_sample;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_alpha_out;
   logic signed [31:0] rsp_beta_out;
   logic               csr_wr_en;
   logic [3:0]         csr_index;
   logic [31:0]        csr_wdata;

   // predictor copy of the coefficients and the filter delay line
   logic signed [31:0] tap_a1, tap_a2, tap_alpha_b0, tap_beta_b0;
   q40_type            alpha_w1, alpha_w2, beta_w1, beta_w2;

   filter_out_type expected_outputs[$];
   filter_out_type due_out;
   plan_row_type   directed_plan [PLAN_ROWS];
   int          errors = 0;
   int          samples_taken = 0;
   int          cycle_count = 0;
   int          burst_left = 0;
   int          gap_len;

   sogi_quadrature_filter_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sample    (req_sample),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_alpha_out (rsp_alpha_out),
      .rsp_beta_out  (rsp_beta_out),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // x * c with c in Q30: upper part times c plus the fraction product shifted down
   function automatic q40_type q30_scale(input q40_type x, input logic signed [32:0] c);
      q40_type c_wide, upper, frac_prod;
      c_wide = 64'(c);
      upper = x >>> COEF_FRAC;
      frac_prod = {34'd0, x[COEF_FRAC-1:0]} * c_wide;
      return upper * c_wide + (frac_prod >>> COEF_FRAC);
   endfunction

   function automatic logic signed [31:0] clamp_out(input q40_type v);
      q40_type s;
      s = v >>> OUT_SHIFT;
      if (s > OUT_MAX) begin
         return 32'h7FFF_FFFF;
      end else if (s < OUT_MIN) begin
         return 32'h8000_0000;
      end
      return s[31:0];
   endfunction

   function automatic filter_out_type filter_step(input logic signed [31:0] s);
      q40_type u, in_a, in_b, va, vb;
      logic signed [32:0] a1, a2, ab0, bb0;
      filter_out_type r;
      a1 = 33'(tap_a1);
      a2 = 33'(tap_a2);
      ab0 = 33'(tap_alpha_b0);
      bb0 = 33'(tap_beta_b0);
      u = 64'(s);
      u = u <<< OUT_SHIFT;

      in_a = u - q30_scale(alpha_w1, a1) - q30_scale(alpha_w2, a2);
      va = q30_scale(in_a, ab0) + q30_scale(alpha_w2, -ab0);
      alpha_w2 = alpha_w1;
      alpha_w1 = in_a;

      in_b = u - q30_scale(beta_w1, a1) - q30_scale(beta_w2, a2);
      vb = q30_scale(in_b, bb0) + q30_scale(beta_w1, bb0 <<< 1) + q30_scale(beta_w2, bb0);
      beta_w2 = beta_w1;
      beta_w1 = in_b;

      r.alpha = clamp_out(va);
      r.beta = clamp_out(vb);
      return r;
   endfunction

   function automatic logic [31:0] pick_coef(input coef_style_type style,
                                             input logic [31:0] nominal);
      case (style)
         COEF_LINE:   return nominal + $urandom_range(0, 4096) - 2048;
         COEF_RANDOM: return $urandom();
         default: begin
            case ($urandom_range(0, 4))
               0:       return 32'h8000_0000;
               1:       return 32'h7FFF_FFFF;
               2:       return 32'h0000_0000;
               3:       return 32'hFFFF_FFFF;
               default: return 32'h4000_0000;
            endcase
         end
      endcase
   endfunction

   // called at a falling edge; returns at a falling edge
   task automatic offer_sample(input logic signed [31:0] s, input bit known,
                               input filter_out_type typed);
      filter_out_type predicted;
      req_valid <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = filter_step(s);
      expected_outputs.push_back(known ? typed : predicted);
      samples_taken++;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
         if (gap_len != 0) begin
            req_valid <= 1'b0;
            repeat (gap_len) @(negedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // coefficients change only with the filter drained
   task automatic write_coef(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      req_valid <= 1'b0;
      while (expected_outputs.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_A1:       tap_a1 = data;
         CSR_A2:       tap_a2 = data;
         CSR_ALPHA_B0: tap_alpha_b0 = data;
         CSR_BETA_B0:  tap_beta_b0 = data;
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outputs.size() == 0) begin
            $error("unexpected item: alpha_out %0d, beta_out %0d", rsp_alpha_out,
                   rsp_beta_out);
            errors++;
         end else begin
            due_out = expected_outputs.pop_front();
            if (rsp_alpha_out !== due_out.alpha) begin
               $error("alpha_out: expected %0d, got %0d", due_out.alpha, rsp_alpha_out);
               errors++;
            end
            if (rsp_beta_out !== due_out.beta) begin
               $error("beta_out: expected %0d, got %0d", due_out.beta, rsp_beta_out);
               errors++;
            end
         end
      end
   end

   // receiver: stall patterns in segments, plus one long hold-off that backs up the filter
   initial begin
      int                seg_len;
      stall_pattern_type pattern;
      bit                held_off;
      held_off = 1'b0;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         seg_len = $urandom_range(8, 80);
         pattern = stall_pattern_type'($urandom_range(0, 3));
         repeat (seg_len) begin
            if (!held_off && samples_taken >= HOLD_AT) begin
               held_off = 1'b1;
               rsp_stall <= 1'b1;
               repeat (HOLD_CYCLES) @(negedge clock);
            end
            case (pattern)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HALF:  rsp_stall <= ($urandom_range(0, 1) != 0);
               default:     rsp_stall <= ($urandom_range(0, 7) != 0);
            endcase
            @(negedge clock);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      coef_style_type     style;
      logic signed [31:0] s;
      filter_out_type     typed;
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      tap_a1 = '0;
      tap_a2 = '0;
      tap_alpha_b0 = '0;
      tap_beta_b0 = '0;
      alpha_w1 = '0;
      alpha_w2 = '0;
      beta_w1 = '0;
      beta_w2 = '0;

      // zero coefficients give zero out for any sample; then unity b0 to force
      // saturation; then min/max coefficients for wrap and the negated -2^31 b0
      directed_plan = '{
         '{ROW_SAMPLE_KNOWN, '0, 32'h0000_0000, 32'h0, 32'h0},
         '{ROW_SAMPLE_KNOWN, '0, 32'h0000_0001, 32'h0, 32'h0},
         '{ROW_SAMPLE_KNOWN, '0, 32'hFFFF_FFFF, 32'h0, 32'h0},
         '{ROW_SAMPLE_KNOWN, '0, 32'h7FFF_FFFF, 32'h0, 32'h0},
         '{ROW_SAMPLE_KNOWN, '0, 32'h8000_0000, 32'h0, 32'h0},
         '{ROW_SAMPLE_KNOWN, '0, 32'h5555_5555, 32'h0, 32'h0},
         '{ROW_SAMPLE_KNOWN, '0, 32'hAAAA_AAAA, 32'h0, 32'h0},
         '{ROW_WRITE, CSR_ALPHA_B0, 32'h4000_0000, 32'h0, 32'h0},
         '{ROW_WRITE, CSR_BETA_B0, 32'h4000_0000, 32'h0, 32'h0},
         '{ROW_SAMPLE, '0, 32'h7FFF_FFFF, 32'h0, 32'h0},
         '{ROW_SAMPLE, '0, 32'h7FFF_FFFF, 32'h0, 32'h0},
         '{ROW_SAMPLE, '0, 32'h8000_0000, 32'h0, 32'h0},
         '{ROW_SAMPLE, '0, 32'h8000_0000, 32'h0, 32'h0},
         '{ROW_SAMPLE, '0, 32'h7FFF_FFFF, 32'h0, 32'h0},
         '{ROW_WRITE, CSR_A1, 32'h8000_0000, 32'h0, 32'h0},
         '{ROW_WRITE, CSR_A2, 32'h7FFF_FFFF, 32'h0, 32'h0},
         '{ROW_WRITE, CSR_ALPHA_B0, 32'h8000_0000, 32'h0, 32'h0},
         '{ROW_WRITE, CSR_BETA_B0, 32'h8000_0000, 32'h0, 32'h0},
         '{ROW_WRITE, CSR_SPARE_FIRST, 32'hFFFF_FFFF, 32'h0, 32'h0},
         '{ROW_WRITE, CSR_SPARE_LAST, 32'h1234_5678, 32'h0, 32'h0},
         '{ROW_SAMPLE, '0, 32'h7FFF_FFFF, 32'h0, 32'h0},
         '{ROW_SAMPLE, '0, 32'h8000_0000, 32'h0, 32'h0},
         '{ROW_SAMPLE, '0, 32'h0000_0001, 32'h0, 32'h0},
         '{ROW_SAMPLE, '0, 32'h0000_0000, 32'h0, 32'h0},
         '{ROW_WRITE, CSR_A1, 32'h7FFF_FFFF, 32'h0, 32'h0},
         '{ROW_WRITE, CSR_A2, 32'h8000_0000, 32'h0, 32'h0},
         '{ROW_WRITE, CSR_ALPHA_B0, 32'h7FFF_FFFF, 32'h0, 32'h0},
         '{ROW_WRITE, CSR_BETA_B0, 32'h7FFF_FFFF, 32'h0, 32'h0},
         '{ROW_SAMPLE, '0, 32'h1234_5678, 32'h0, 32'h0},
         '{ROW_SAMPLE, '0, 32'hEDCB_A988, 32'h0, 32'h0},
         '{ROW_SAMPLE, '0, 32'h0000_0000, 32'h0, 32'h0}
      };

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < PLAN_ROWS; i++) begin
         typed.alpha = directed_plan[i].alpha;
         typed.beta = directed_plan[i].beta;
         case (directed_plan[i].kind)
            ROW_WRITE:  write_coef(directed_plan[i].index, directed_plan[i].data);
            ROW_SAMPLE: offer_sample(directed_plan[i].data, 1'b0, typed);
            default:    offer_sample(directed_plan[i].data, 1'b1, typed);
         endcase
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         style = (p == 0) ? COEF_LINE : coef_style_type'($urandom_range(0, 2));
         write_coef(CSR_A1, pick_coef(style, LINE_A1));
         write_coef(CSR_A2, pick_coef(style, LINE_A2));
         write_coef(CSR_ALPHA_B0, pick_coef(style, LINE_ALPHA_B0));
         write_coef(CSR_BETA_B0, pick_coef(style, LINE_BETA_B0));
         write_coef(CSR_IDX_W'($urandom_range(CSR_SPARE_LAST, CSR_SPARE_FIRST)), $urandom());
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            case (sample_span_type'($urandom_range(0, 3)))
               SPAN_FULL: s = $urandom();
               SPAN_TINY: s = $urandom_range(0, 255) - 128;
               default:   s = $urandom_range(0, 2 * GRID_PEAK) - GRID_PEAK;
            endcase
            offer_sample(s, 1'b0, typed);
         end
      end

      req_valid <= 1'b0;
      while (expected_outputs.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
